// File: sv/emp_pkg.sv
// ----------------------------------------------------------------------------
// emp_pkg - shared types and helpers for the multi-turn encoder position core
// Item structs, opcode and register codes, mask decode and saturation.
// ----------------------------------------------------------------------------
package emp_pkg;

  localparam int PosW   = 48;
  localparam int RawW   = 64;
  localparam int ScaleW = 32;
  localparam int TurnW  = 32;
  localparam int ShW    = 6;
  // wide enough for turn_count << 63 plus a 64-bit count
  localparam int SatW   = 97;

  localparam logic signed [PosW-1:0]  PosMax  = {1'b0, {(PosW-1){1'b1}}};
  localparam logic signed [PosW-1:0]  PosMin  = {1'b1, {(PosW-1){1'b0}}};
  localparam logic signed [TurnW-1:0] TurnMax = {1'b0, {(TurnW-1){1'b1}}};
  localparam logic signed [TurnW-1:0] TurnMin = {1'b1, {(TurnW-1){1'b0}}};

  typedef enum logic [1:0] {
    OP_SAMPLE    = 2'd0,
    OP_SET_POS   = 2'd1,
    OP_LOAD_OFS  = 2'd2,
    OP_SET_HOMED = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_RAW_MASK = 2'd0,
    CFG_SCALE    = 2'd1,
    CFG_ENC_TYPE = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    op_t                     opcode;
    logic [RawW-1:0]         raw_value;
    logic                    fault;
    logic signed [PosW-1:0]  value;
    logic                    homed_flag;
  } in_item_t;

  typedef struct packed {
    logic signed [PosW-1:0]  position;
    logic signed [PosW-1:0]  raw_position;
    logic                    homed;
    logic                    mask_invalid;
  } out_item_t;

  // raw_mask with its decode, worked out once per register write
  typedef struct packed {
    logic [RawW-1:0]  mask;
    logic [ShW-1:0]   tz;       // trailing zeros
    logic [ShW-1:0]   width;    // counter width, low bits (64 reads as 0)
    logic             track;    // width between 1 and 63
    logic             invalid;  // nonzero and not contiguous
    logic [RawW-1:0]  limit;    // floor(2/3 * 2^width)
  } mask_cfg_t;

  // stage A to stage B
  typedef struct packed {
    op_t                     opcode;
    logic                    bad;
    logic signed [PosW-1:0]  value;
    logic                    homed_flag;
    logic signed [PosW-1:0]  raw_pos;
    logic                    invalid;
  } turn_out_t;

  function automatic mask_cfg_t mask_decode(input logic [RawW-1:0] v);
    mask_cfg_t       d;
    logic [RawW-1:0] m;
    logic [ShW:0]    ones;
    d.mask = v;
    d.tz   = '0;
    for (int i = RawW - 1; i >= 0; i--) begin
      if (v[i]) d.tz = ShW'(i);
    end
    m    = v >> d.tz;
    ones = '0;
    for (int i = 0; i < RawW; i++) begin
      ones = ones + {{ShW{1'b0}}, v[i]};
    end
    d.invalid = (v != '0) && ((m & (m + {{(RawW-1){1'b0}}, 1'b1})) != '0);
    d.width   = ones[ShW-1:0];
    d.track   = (ones != '0) && !ones[ShW];
    // floor(2^(w+1)/3) is the top w+1 bits of 0101...01
    d.limit   = {(RawW/2){2'b01}} >> (ShW'(RawW - 1) - ones[ShW-1:0]);
    return d;
  endfunction

  function automatic logic signed [PosW-1:0] sat_pos(input logic signed [SatW-1:0] v);
    logic fits;
    fits = (&v[SatW-1:PosW-1]) || !(|v[SatW-1:PosW-1]);
    if (fits)          return v[PosW-1:0];
    else if (v[SatW-1]) return PosMin;
    else               return PosMax;
  endfunction

endpackage

// File: sv/emp_turn.sv
// ----------------------------------------------------------------------------
// emp_turn - count extraction and turn tracking
// Masks and aligns the raw word, counts wraps and builds the multi-turn count.
// ----------------------------------------------------------------------------
module emp_turn
  import emp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  logic       in_vld,
  input  in_item_t   item,
  input  mask_cfg_t  mcfg,
  output logic       res_vld_r,
  output turn_out_t  res_r
);

  logic [RawW-1:0]         prev_r, prev_nxt;
  logic signed [TurnW-1:0] turn_r, turn_nxt, turn_smp;
  logic signed [PosW-1:0]  raw_r, raw_nxt, raw_smp;
  logic [RawW-1:0]         count;
  logic                    drop, rise, smp, bad, go;
  logic signed [SatW-1:0]  wide;
  turn_out_t               res_nxt;

  always_comb begin
    count = (item.raw_value & mcfg.mask) >> mcfg.tz;
    drop  = (prev_r > count) && ((prev_r - count) > mcfg.limit);
    rise  = (count > prev_r) && ((count - prev_r) > mcfg.limit);

    if (!mcfg.track)                     turn_smp = '0;
    else if (drop && turn_r != TurnMax)  turn_smp = turn_r + TurnW'(1);
    else if (rise && turn_r != TurnMin)  turn_smp = turn_r - TurnW'(1);
    else                                 turn_smp = turn_r;

    // turn_smp is zero whenever the width is 0 or 64
    wide    = (SatW'(turn_smp) <<< mcfg.width) + SatW'(count);
    raw_smp = sat_pos(wide);

    smp = (item.opcode == OP_SAMPLE);
    bad = item.fault || mcfg.invalid;
    go  = en && in_vld;

    prev_nxt = prev_r;
    turn_nxt = turn_r;
    raw_nxt  = raw_r;
    if (go && smp) begin
      if (bad) begin
        raw_nxt = '0;
      end else begin
        prev_nxt = count;
        turn_nxt = turn_smp;
        raw_nxt  = raw_smp;
      end
    end

    res_nxt.opcode     = item.opcode;
    res_nxt.bad        = bad;
    res_nxt.value      = item.value;
    res_nxt.homed_flag = item.homed_flag;
    res_nxt.raw_pos    = raw_nxt;
    res_nxt.invalid    = mcfg.invalid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r    <= '0;
      turn_r    <= '0;
      raw_r     <= '0;
      res_vld_r <= 1'b0;
    end else begin
      prev_r <= prev_nxt;
      turn_r <= turn_nxt;
      raw_r  <= raw_nxt;
      if (en) res_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) res_r <= res_nxt;
  end

endmodule

// File: sv/emp_scale.sv
// ----------------------------------------------------------------------------
// emp_scale - scaling, offset and homing
// Two-stage scale*raw product with rounding, offset add and position state.
// ----------------------------------------------------------------------------
module emp_scale
  import emp_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     a_vld,
  input  turn_out_t                a,
  input  logic signed [ScaleW-1:0] scale,
  input  logic                     enc_type,
  input  logic                     home_set,
  output logic                     out_vld_r,
  output out_item_t                out_r
);

  localparam int HalfW = PosW / 2;
  localparam int PlW   = HalfW + ScaleW;
  localparam int PhW   = (PosW - HalfW) + ScaleW;
  localparam int SumW  = PhW + HalfW + 1;
  localparam int QW    = 64;

  typedef struct packed {
    turn_out_t        t;
    logic             neg;
    logic [PlW:0]     pl;   // low partial product plus rounding half
    logic [PhW-1:0]   ph;
  } prod_t;

  logic                    b_vld_r;
  prod_t                   b_r, b_nxt;
  logic [PosW-1:0]         rmag;
  logic [ScaleW-1:0]       smag;
  logic [PlW-1:0]          pl_raw;

  logic signed [PosW-1:0]  ofs_r, ofs_nxt, act_r, act_nxt;
  logic                    homed_r, homed_nxt;
  logic [SumW-1:0]         s;
  logic                    ovf;
  logic [QW-1:0]           q;
  logic signed [SatW-1:0]  q_s;
  logic signed [PosW-1:0]  pos_smp, diff, ofs_set;
  logic                    go;
  out_item_t               out_nxt;

  // stage B: magnitudes and partial products
  always_comb begin
    rmag   = a.raw_pos[PosW-1] ? PosW'(-a.raw_pos) : a.raw_pos;
    smag   = scale[ScaleW-1] ? ScaleW'(-scale) : scale;
    pl_raw = rmag[HalfW-1:0] * smag;
    b_nxt.t   = a;
    b_nxt.neg = a.raw_pos[PosW-1] ^ scale[ScaleW-1];
    b_nxt.pl  = (PlW+1)'(pl_raw) + (PlW+1)'(128);
    b_nxt.ph  = rmag[PosW-1:HalfW] * smag;
  end

  // stage C: round off the 8 fraction bits of the Q.8 scale, add offset, update position state
  always_comb begin
    s   = {b_r.ph, {HalfW{1'b0}}} + SumW'(b_r.pl);
    ovf = |s[SumW-1:72];
    q   = s[71:8];
    q_s = b_r.neg ? -SatW'(q) : SatW'(q);
    if (ovf) pos_smp = b_r.neg ? PosMin : PosMax;
    else     pos_smp = sat_pos(q_s + SatW'(ofs_r));

    diff    = sat_pos(SatW'(b_r.t.value) - SatW'(act_r));
    ofs_set = sat_pos(SatW'(ofs_r) + SatW'(diff));

    go        = en && b_vld_r;
    ofs_nxt   = ofs_r;
    act_nxt   = act_r;
    homed_nxt = homed_r;
    if (go) begin
      case (b_r.t.opcode)
        OP_SAMPLE:    act_nxt = b_r.t.bad ? ofs_r : pos_smp;
        OP_SET_POS: begin
          ofs_nxt = ofs_set;
          act_nxt = b_r.t.value;
        end
        OP_LOAD_OFS:  ofs_nxt = b_r.t.value;
        OP_SET_HOMED: homed_nxt = b_r.t.homed_flag;
        default:      act_nxt = act_r;
      endcase
    end
    if (home_set) homed_nxt = 1'b1;

    out_nxt.position     = act_nxt;
    out_nxt.raw_position = b_r.t.raw_pos;
    out_nxt.homed        = homed_nxt | enc_type;
    out_nxt.mask_invalid = b_r.t.invalid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
      ofs_r     <= '0;
      act_r     <= '0;
      homed_r   <= 1'b0;
    end else begin
      ofs_r   <= ofs_nxt;
      act_r   <= act_nxt;
      homed_r <= homed_nxt;
      if (en) begin
        b_vld_r   <= a_vld;
        out_vld_r <= b_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_r   <= b_nxt;
      out_r <= out_nxt;
    end
  end

endmodule

// File: sv/encoder_multiturn_position_core.sv
// ----------------------------------------------------------------------------
// encoder_multiturn_position_core - multi-turn encoder position
// Turns raw counter samples into a multi-turn count and a scaled position.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall carries one in_item_t per transfer: a counter sample or
//   a command (set position, load offset, set homed flag). Every transfer
//   gives exactly one out_item_t on out_valid/out_stall, in order.
//   Throughput is one item per cycle while the output is not stalled. The
//   pipeline is input register, count and turn stage, partial-product stage,
//   then round/offset stage feeding the output register; the scale*raw
//   product is split over the last two.
//   While out_valid is high and out_stall is asserted the whole pipeline holds
//   and in_stall is raised; nothing is dropped.
//   cfg_valid/cfg_ready writes raw_mask (0), scale (1), encoder_type (2) and is
//   always ready; write it only while no items are in flight. Writing
//   encoder_type = 1 also sets the homed flag.
//   Synchronous reset clears the valid flags and the position state: mask all ones, scale and offset zero,
//   turn count and positions zero, not homed.
// ----------------------------------------------------------------------------
module encoder_multiturn_position_core
  import emp_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,

  input  logic            in_valid,
  output logic            in_stall,
  input  in_item_t        in_item,

  output logic            out_valid,
  input  logic            out_stall,
  output out_item_t       out_item,

  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [1:0]      cfg_index,
  input  logic [RawW-1:0] cfg_data
);

  logic                     en;
  logic                     cfg_we, home_set;
  mask_cfg_t                mcfg_r;
  logic signed [ScaleW-1:0] scale_r;
  logic                     enc_type_r;

  logic                     s0_vld_r;
  in_item_t                 s0_r;
  logic                     a_vld;
  turn_out_t                a_res;

  assign en        = !out_valid || !out_stall;
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign home_set  = cfg_we && (cfg_reg_t'(cfg_index) == CFG_ENC_TYPE) && cfg_data[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mcfg_r     <= mask_decode({RawW{1'b1}});
      scale_r    <= '0;
      enc_type_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_RAW_MASK: mcfg_r     <= mask_decode(cfg_data);
        CFG_SCALE:    scale_r    <= cfg_data[ScaleW-1:0];
        CFG_ENC_TYPE: enc_type_r <= cfg_data[0];
        default:      enc_type_r <= enc_type_r;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (en) begin
      s0_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_valid) s0_r <= in_item;
  end

  emp_turn u_turn (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_vld    (s0_vld_r),
    .item      (s0_r),
    .mcfg      (mcfg_r),
    .res_vld_r (a_vld),
    .res_r     (a_res)
  );

  emp_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .a_vld     (a_vld),
    .a         (a_res),
    .scale     (scale_r),
    .enc_type  (enc_type_r),
    .home_set  (home_set),
    .out_vld_r (out_valid),
    .out_r     (out_item)
  );

endmodule
